// File: src/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and field widths for the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

    typedef enum logic [1:0] {
        CMD_ALLOC     = 2'd0,
        CMD_FREE_ADDR = 2'd1,
        CMD_MARK_USED = 2'd2,
        CMD_MARK_FREE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_NOFREE = 2'd1,
        ST_RANGE  = 2'd2
    } t_status;

    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 32;
    localparam int INDEX_W    = 15;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    localparam logic [COUNT_W-1:0] PAGE_COUNT_RST = 16'd32768;

endpackage

// File: src/bpfa_ram.sv
// ----------------------------------------------------------------------------
// bpfa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/bitmap_page_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_top
// First-fit page frame allocator over a used-page bitmap held in block RAM.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser carries the command (allocate,
// free by byte address, mark page used, mark page free), tdata the byte
// address and page number. Each request yields one beat on m_axis: tuser is
// the status, tdata the granted address and the free page count.
// The cfg channel writes the page count; it is always ready.
// After reset a clearing pass writes every bitmap word to all ones, one word
// per cycle; no request is taken during that pass. The free count starts at
// zero. An out-of-range page goes straight to the output state; free and mark
// read the RAM word, then modify it and write it back (S_RMW) before output.
// Allocate scans bitmap words one per cycle through the RAM read port,
// starting at the lowest word that may hold a free page; it visits at most
// ceil(limit / WORD_BITS) words, 1024 at the defaults. One request is in
// work at a time; the next is accepted once the result is loaded and the
// state machine is back in idle.
// The result sits in an output register; the next request is accepted while
// it waits, and that request's result is held until the receiver takes the
// earlier beat.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_top
    import bpfa_pkg::*;
#(
    parameter int MAX_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096,
    parameter int WORD_BITS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [COUNT_W-1:0]    i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // byte_address, page_index, pad
    input  logic [CMD_W-1:0]      s_axis_tuser,  // cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // granted_address, free_pages
    output logic [STATUS_W-1:0]   m_axis_tuser   // status
);

    localparam int PBL       = $clog2(PAGE_BYTES);
    localparam int WBL       = $clog2(WORD_BITS);
    localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WCW       = AW + 1;
    localparam int PGW       = ADDR_W - PBL;
    localparam int LW0       = $clog2(MAX_PAGES + 1);
    localparam int LW        = (LW0 > COUNT_W) ? LW0 : COUNT_W;
    localparam int CW        = (PGW > LW) ? PGW : LW;
    localparam int FCW       = $clog2(MAX_PAGES + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW,
        S_SCAN,
        S_OUT
    } t_state;

    t_state                r_state, n_state;
    logic [AW-1:0]         r_clr, n_clr;
    logic [FCW-1:0]        r_free, n_free;
    logic [AW-1:0]         r_hint, n_hint;
    logic [COUNT_W-1:0]    r_page_count, n_page_count;
    logic                  r_out_valid, n_out_valid;
    logic                  r_chk_v, n_chk_v;

    t_cmd                  r_cmd, n_cmd;
    logic [CW-1:0]         r_page, n_page;
    logic [WCW-1:0]        r_ptr, n_ptr;
    logic [AW-1:0]         r_chk_addr, n_chk_addr;
    t_status               r_status, n_status;
    logic [ADDR_W-1:0]     r_grant, n_grant;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_BITS-1:0]  rd_data;

    logic [LW-1:0]         lim;
    logic [WCW-1:0]        lim_words;
    logic [WCW-1:0]        lim_full;
    logic [WBL-1:0]        lim_part;
    t_cmd                  in_cmd;
    logic [CW-1:0]         in_page;
    logic [AW-1:0]         in_word;
    logic [AW-1:0]         page_word;
    logic [WBL-1:0]        page_bit;
    logic                  bit_was;
    logic                  set_used;
    logic [WORD_BITS-1:0]  bit_sel;
    logic [WORD_BITS-1:0]  cand;
    logic                  scan_hit;
    logic [WBL-1:0]        scan_idx;
    logic                  scan_rd;

    bpfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    assign lim       = (LW'(r_page_count) > LW'(MAX_PAGES)) ? LW'(MAX_PAGES)
                                                            : LW'(r_page_count);
    assign lim_words = WCW'(({1'b0, lim} + (LW + 1)'(WORD_BITS - 1)) >> WBL);
    assign lim_full  = WCW'(lim >> WBL);
    assign lim_part  = lim[WBL-1:0];

    assign in_cmd  = t_cmd'(s_axis_tuser);
    assign in_page = (in_cmd == CMD_FREE_ADDR)
                   ? CW'(s_axis_tdata[ADDR_W-1:PBL])
                   : CW'(s_axis_tdata[ADDR_W+INDEX_W-1:ADDR_W]);
    assign in_word = in_page[AW+WBL-1:WBL];

    assign page_word = r_page[AW+WBL-1:WBL];
    assign page_bit  = r_page[WBL-1:0];
    assign bit_sel   = WORD_BITS'(1) << page_bit;
    assign bit_was   = rd_data[page_bit];
    assign set_used  = (r_cmd == CMD_MARK_USED);
    assign scan_rd   = (r_ptr < lim_words);

    always_comb begin
        logic chk_full;
        chk_full = (WCW'(r_chk_addr) < lim_full);
        cand     = '0;
        scan_idx = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            cand[b] = ~rd_data[b] & (chk_full || (WBL'(b) < lim_part));
        end
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (cand[b]) begin
                scan_idx = WBL'(b);
            end
        end
        scan_hit = |cand;
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_free       = r_free;
        n_hint       = r_hint;
        n_page_count = r_page_count;
        n_out_valid  = r_out_valid;
        n_chk_v      = r_chk_v;
        n_cmd        = r_cmd;
        n_page       = r_page;
        n_ptr        = r_ptr;
        n_chk_addr   = r_chk_addr;
        n_status     = r_status;
        n_grant      = r_grant;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_waddr    = r_clr;
        ram_wdata    = '1;
        ram_re       = 1'b0;
        ram_raddr    = in_word;

        if (i_cfg_valid) begin
            n_page_count = i_cfg_data;
        end
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_clr  = r_clr + 1'b1;
                if (r_clr == AW'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd    = in_cmd;
                    n_page   = in_page;
                    n_status = ST_DONE;
                    n_grant  = '0;
                    if (in_cmd == CMD_ALLOC) begin
                        n_ptr   = WCW'(r_hint);
                        n_chk_v = 1'b0;
                        n_state = S_SCAN;
                    end else if (in_page >= CW'(lim)) begin
                        n_status = ST_RANGE;
                        n_state  = S_OUT;
                    end else begin
                        ram_re  = 1'b1;
                        n_state = S_RMW;
                    end
                end
            end
            S_RMW: begin
                ram_we    = 1'b1;
                ram_waddr = page_word;
                ram_wdata = set_used ? (rd_data | bit_sel) : (rd_data & ~bit_sel);
                if (set_used && !bit_was) begin
                    n_free = r_free - 1'b1;
                end else if (!set_used && bit_was) begin
                    n_free = r_free + 1'b1;
                    if (page_word < r_hint) begin
                        n_hint = page_word;
                    end
                end
                n_state = S_OUT;
            end
            S_SCAN: begin
                ram_re     = scan_rd;
                ram_raddr  = r_ptr[AW-1:0];
                n_chk_v    = scan_rd;
                n_chk_addr = r_ptr[AW-1:0];
                if (scan_rd) begin
                    n_ptr = r_ptr + 1'b1;
                end
                if (r_chk_v && scan_hit) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_chk_addr;
                    ram_wdata = rd_data | (WORD_BITS'(1) << scan_idx);
                    n_free    = r_free - 1'b1;
                    n_hint    = r_chk_addr;
                    n_grant   = ADDR_W'({r_chk_addr, scan_idx}) << PBL;
                    n_status  = ST_DONE;
                    n_state   = S_OUT;
                end else if (!r_chk_v && !scan_rd) begin
                    n_status = ST_NOFREE;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = {COUNT_W'(r_free), r_grant};
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_free       <= '0;
            r_hint       <= '0;
            r_page_count <= PAGE_COUNT_RST;
            r_out_valid  <= 1'b0;
            r_chk_v      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_free       <= n_free;
            r_hint       <= n_hint;
            r_page_count <= n_page_count;
            r_out_valid  <= n_out_valid;
            r_chk_v      <= n_chk_v;
        end
        r_cmd        <= n_cmd;
        r_page       <= n_page;
        r_ptr        <= n_ptr;
        r_chk_addr   <= n_chk_addr;
        r_status     <= n_status;
        r_grant      <= n_grant;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

endmodule

// File: src/bpfa_checker.sv
// ----------------------------------------------------------------------------
// bpfa_checker
// Port-level assertions for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bpfa_checker
    import bpfa_pkg::*;
#(
    parameter int PAGE_BYTES = 4096
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,   // granted_address, free_pages
    input logic [STATUS_W-1:0]   m_axis_tuser    // status
);

    localparam int PBL = $clog2(PAGE_BYTES);

    logic       in_beat;
    logic       out_beat;
    logic [1:0] r_outst;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= '0;
        end else if (in_beat && !out_beat) begin
            r_outst <= r_outst + 1'b1;
        end else if (!in_beat && out_beat) begin
            r_outst <= r_outst - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    a_beat_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> r_outst != 2'd0)
        else $error("output beat without a pending request");

    a_outst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outst != 2'd3)
        else $error("too many requests in flight");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_DONE |-> m_axis_tdata[ADDR_W-1:0] == '0)
        else $error("nonzero address on a failed request");

    a_grant_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[PBL-1:0] == '0)
        else $error("granted address not page aligned");

endmodule

bind bitmap_page_frame_allocator_top bpfa_checker #(
    .PAGE_BYTES (PAGE_BYTES)
) u_bpfa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
